@@ hw/rtl/acs_pkg.sv @@
// shared types, constants and arithmetic helpers for the cursor sprite pipeline
`default_nettype none
package acs_pkg;

  localparam int RING_WIDTH = 2;
  localparam int MAX_RADIUS = 50;

  localparam int COORD_W    = 7;
  localparam int RADIUS_W   = 6;
  localparam int CIDX_W     = 4;
  localparam int CHAN_W     = 8;
  localparam int DWORD_W    = 32;
  localparam int ADDR_W     = 4;

  localparam int RAD_W      = $clog2(MAX_RADIUS + RING_WIDTH + 1);
  localparam int DIAM_W     = $clog2(2 * (MAX_RADIUS + RING_WIDTH) + 3);
  localparam int DX_W       = DIAM_W + 3;
  localparam int OFF_W      = DIAM_W;
  localparam int SUMSQ_W    = 2 * OFF_W + 1;
  localparam int FRAC_SHIFT = 14;
  localparam int RAD_BITS   = SUMSQ_W + FRAC_SHIFT;
  localparam int ROOT_W     = (RAD_BITS + 1) / 2;
  localparam int RADICAND_W = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQ_PER_STAGE = 3;
  localparam int SQ_STAGES  = (ROOT_W + SQ_PER_STAGE - 1) / SQ_PER_STAGE;
  localparam int LATENCY    = SQ_STAGES + 5;

  localparam int COV_W      = 9;
  localparam int COV_ONE    = 256;
  localparam int CALC_W     = ROOT_W + 3;
  localparam int PROD_W     = COV_W + CHAN_W;

  localparam logic [1:0] REG_RADIUS      = 2'd0;
  localparam logic [1:0] REG_RING_MODE   = 2'd1;
  localparam logic [1:0] REG_COLOR_INDEX = 2'd2;

  localparam logic [CIDX_W-1:0] COLOR_BLACK  = 4'd0;
  localparam logic [CIDX_W-1:0] COLOR_RED    = 4'd1;
  localparam logic [CIDX_W-1:0] COLOR_GREEN  = 4'd2;
  localparam logic [CIDX_W-1:0] COLOR_BLUE   = 4'd3;
  localparam logic [CIDX_W-1:0] COLOR_ORANGE = 4'd4;
  localparam logic [CIDX_W-1:0] COLOR_YELLOW = 4'd5;
  localparam logic [CIDX_W-1:0] COLOR_PURPLE = 4'd6;
  localparam logic [CIDX_W-1:0] COLOR_CYAN   = 4'd7;
  localparam logic [CIDX_W-1:0] COLOR_WHITE  = 4'd8;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd5;
  localparam logic [CIDX_W-1:0]   CIDX_RESET   = COLOR_RED;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [COORD_W-1:0] sprite_diameter;
  } out_word_t;

  typedef struct packed {
    logic [RAD_W-1:0]  radius;
    logic              ring_mode;
    logic [CIDX_W-1:0] color_index;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               in_sprite;
    logic [SUMSQ_W-1:0] sum_sq;
  } sq_t;

  typedef struct packed {
    logic              valid;
    logic              in_sprite;
    logic [ROOT_W-1:0] dist_q8;
  } dist_t;

  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } argb_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } root_state_t;

  // sprite side length 2*(r+border)+2
  function automatic logic [DIAM_W-1:0] diameter(cfg_t c);
    logic [RAD_W-1:0] half;
    half = c.radius + (c.ring_mode ? RAD_W'(RING_WIDTH) : RAD_W'(0));
    return DIAM_W'({half, 1'b0}) + DIAM_W'(2);
  endfunction

  function automatic logic [3*CHAN_W-1:0] palette(logic [CIDX_W-1:0] idx);
    logic [3*CHAN_W-1:0] rgb;
    case (idx)
      COLOR_BLACK:  rgb = 24'h000000;
      COLOR_RED:    rgb = 24'hFF0000;
      COLOR_GREEN:  rgb = 24'h00C000;
      COLOR_BLUE:   rgb = 24'h0055FF;
      COLOR_ORANGE: rgb = 24'hFFA500;
      COLOR_YELLOW: rgb = 24'hFFFF00;
      COLOR_PURPLE: rgb = 24'h800080;
      COLOR_CYAN:   rgb = 24'h00FFFF;
      default:      rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

  // one restoring square root digit
  function automatic root_state_t sqrt_step(root_state_t s, logic [1:0] pair);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    root_state_t n;
    cur   = {s.rem[REM_W-3:0], pair};
    trial = {1'b0, s.root, 2'b01};
    if (cur >= trial) begin
      n.rem  = cur - trial;
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = cur;
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  // q1.8 coverage of a disc of radius r at q.8 distance dist_q8
  function automatic logic [COV_W-1:0] disc_cov(logic [RAD_W-1:0] r,
                                                logic [ROOT_W-1:0] dist_q8);
    logic signed [CALC_W-1:0] c;
    c = $signed(CALC_W'({r, 8'd0})) + $signed(CALC_W'(128))
        - $signed(CALC_W'(dist_q8));
    if (c < 0) begin
      return '0;
    end else if (c > $signed(CALC_W'(COV_ONE))) begin
      return COV_W'(COV_ONE);
    end else begin
      return c[COV_W-1:0];
    end
  endfunction

  function automatic logic [CHAN_W-1:0] scale_chan(logic [COV_W-1:0] cov,
                                                   logic [CHAN_W-1:0] val);
    logic [PROD_W-1:0] p;
    p = PROD_W'(cov) * PROD_W'(val) + PROD_W'(128);
    return p[CHAN_W+7:8];
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/antialiased_cursor_sprite_top.sv @@
// top level: register port, configuration clamping and the pixel pipeline
// a word taken with start runs through the geometry, square root and shade registers to out_word and out_strobe
// throughput: one word per cycle; busy stays low, start may be held every cycle
// the square root takes five of the ten stages, three result bits per stage
// reset: synchronous active-low rst_n clears valid bits and the registers to
// radius 5, disc mode, color index 1; no clearing pass
`default_nettype none
module antialiased_cursor_sprite_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  acs_pkg::in_word_t            in_word,
  output logic                         out_strobe,
  output acs_pkg::out_word_t           out_word,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [acs_pkg::ADDR_W-1:0]   paddr,
  input  logic [acs_pkg::DWORD_W-1:0]  pwdata,
  output logic [acs_pkg::DWORD_W-1:0]  prdata,
  output logic                         pready
);

  logic [acs_pkg::RADIUS_W-1:0] radius_r;
  logic                         ring_mode_r;
  logic [acs_pkg::CIDX_W-1:0]   color_index_r;

  logic                         accept;
  logic                         wr_en;
  logic [1:0]                   reg_sel;
  acs_pkg::cfg_t                cfg;
  acs_pkg::sq_t                 sq;
  acs_pkg::dist_t               distance;
  acs_pkg::argb_t               px;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= acs_pkg::RADIUS_RESET;
      ring_mode_r   <= 1'b0;
      color_index_r <= acs_pkg::CIDX_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        acs_pkg::REG_RADIUS:      radius_r      <= pwdata[acs_pkg::RADIUS_W-1:0];
        acs_pkg::REG_RING_MODE:   ring_mode_r   <= pwdata[0];
        acs_pkg::REG_COLOR_INDEX: color_index_r <= pwdata[acs_pkg::CIDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      acs_pkg::REG_RADIUS:      prdata = acs_pkg::DWORD_W'(radius_r);
      acs_pkg::REG_RING_MODE:   prdata = acs_pkg::DWORD_W'(ring_mode_r);
      acs_pkg::REG_COLOR_INDEX: prdata = acs_pkg::DWORD_W'(color_index_r);
      default:                  prdata = '0;
    endcase
  end

  // out-of-range radius and color index saturate
  always_comb begin
    if (radius_r == '0) begin
      cfg.radius = acs_pkg::RAD_W'(1);
    end else if (int'(radius_r) > acs_pkg::MAX_RADIUS) begin
      cfg.radius = acs_pkg::RAD_W'(acs_pkg::MAX_RADIUS);
    end else begin
      cfg.radius = acs_pkg::RAD_W'(radius_r);
    end
    cfg.ring_mode   = ring_mode_r;
    cfg.color_index = (color_index_r > acs_pkg::COLOR_WHITE) ? acs_pkg::COLOR_WHITE
                                                             : color_index_r;
  end

  acs_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_word),
    .cfg     (cfg),
    .sq      (sq)
  );

  acs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .sq       (sq),
    .distance (distance)
  );

  acs_shade u_shade (
    .clk      (clk),
    .rst_n    (rst_n),
    .distance (distance),
    .cfg      (cfg),
    .px       (px)
  );

  assign out_strobe               = px.valid;
  assign out_word.alpha           = px.alpha;
  assign out_word.red             = px.red;
  assign out_word.green           = px.green;
  assign out_word.blue            = px.blue;
  assign out_word.sprite_diameter = acs_pkg::COORD_W'(acs_pkg::diameter(cfg));

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, acs_pkg::LATENCY))
    else $error("result word without a matching input word");

  a_ring_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && ring_mode_r |->
      out_word.red == out_word.alpha && out_word.green == out_word.alpha &&
      out_word.blue == out_word.alpha)
    else $error("ring word is not white");

  a_premul: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |->
      out_word.red <= out_word.alpha && out_word.green <= out_word.alpha &&
      out_word.blue <= out_word.alpha)
    else $error("channel exceeds alpha");

  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe &&
      ($past(in_word.pixel_col, acs_pkg::LATENCY) >= out_word.sprite_diameter ||
       $past(in_word.pixel_row, acs_pkg::LATENCY) >= out_word.sprite_diameter) |->
      out_word.alpha == '0)
    else $error("pixel outside the sprite has coverage");

endmodule
`default_nettype wire

@@ hw/rtl/acs_geom.sv @@
// input capture, centre offsets and sum of squared offsets (three stages)
`default_nettype none
module acs_geom (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  acs_pkg::in_word_t in_word,
  input  acs_pkg::cfg_t    cfg,
  output acs_pkg::sq_t     sq
);

  logic                             v1_r, v2_r, v3_r;
  logic [acs_pkg::COORD_W-1:0]      col1_r, row1_r;
  logic                             in2_r, in3_r;
  logic [acs_pkg::OFF_W-1:0]        adx2_r, ady2_r;
  logic [acs_pkg::SUMSQ_W-1:0]      sum3_r;

  logic [acs_pkg::DIAM_W-1:0]       diam;
  logic signed [acs_pkg::DX_W-1:0]  dxs, dys;
  logic                             in_sprite;
  logic [acs_pkg::OFF_W-1:0]        adx_nxt, ady_nxt;
  logic [acs_pkg::SUMSQ_W-1:0]      sum_nxt;

  assign diam = acs_pkg::diameter(cfg);

  // offsets in half-pixel units from the sprite centre
  always_comb begin
    dxs = $signed(acs_pkg::DX_W'({col1_r, 1'b1})) - $signed(acs_pkg::DX_W'(diam));
    dys = $signed(acs_pkg::DX_W'({row1_r, 1'b1})) - $signed(acs_pkg::DX_W'(diam));
    in_sprite = (acs_pkg::DX_W'(col1_r) < acs_pkg::DX_W'(diam)) &&
                (acs_pkg::DX_W'(row1_r) < acs_pkg::DX_W'(diam));
    adx_nxt = '0;
    ady_nxt = '0;
    if (in_sprite) begin
      adx_nxt = acs_pkg::OFF_W'((dxs < 0) ? -dxs : dxs);
      ady_nxt = acs_pkg::OFF_W'((dys < 0) ? -dys : dys);
    end
    sum_nxt = acs_pkg::SUMSQ_W'(adx2_r) * acs_pkg::SUMSQ_W'(adx2_r)
            + acs_pkg::SUMSQ_W'(ady2_r) * acs_pkg::SUMSQ_W'(ady2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    col1_r <= in_word.pixel_col;
    row1_r <= in_word.pixel_row;
    in2_r  <= in_sprite;
    adx2_r <= adx_nxt;
    ady2_r <= ady_nxt;
    in3_r  <= in2_r;
    sum3_r <= sum_nxt;
  end

  assign sq = '{valid: v3_r, in_sprite: in3_r, sum_sq: sum3_r};

endmodule
`default_nettype wire

@@ hw/rtl/acs_sqrt.sv @@
// pipelined digit-by-digit square root, three result digits per stage
`default_nettype none
module acs_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  acs_pkg::sq_t   sq,
  output acs_pkg::dist_t distance
);

  logic                               vld_r  [acs_pkg::SQ_STAGES];
  logic                               in_r   [acs_pkg::SQ_STAGES];
  acs_pkg::root_state_t               st_r   [acs_pkg::SQ_STAGES];
  logic [acs_pkg::RADICAND_W-1:0]     rad_r  [acs_pkg::SQ_STAGES];

  logic                               vld_in [acs_pkg::SQ_STAGES];
  logic                               in_in  [acs_pkg::SQ_STAGES];
  acs_pkg::root_state_t               st_in  [acs_pkg::SQ_STAGES];
  logic [acs_pkg::RADICAND_W-1:0]     rad_in [acs_pkg::SQ_STAGES];
  acs_pkg::root_state_t               st_nxt [acs_pkg::SQ_STAGES];
  logic [acs_pkg::RADICAND_W-1:0]     rad_nxt[acs_pkg::SQ_STAGES];

  for (genvar s = 0; s < acs_pkg::SQ_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign vld_in[s] = sq.valid;
      assign in_in[s]  = sq.in_sprite;
      assign st_in[s]  = '0;
      assign rad_in[s] = acs_pkg::RADICAND_W'({sq.sum_sq, {acs_pkg::FRAC_SHIFT{1'b0}}});
    end else begin : g_rest
      assign vld_in[s] = vld_r[s-1];
      assign in_in[s]  = in_r[s-1];
      assign st_in[s]  = st_r[s-1];
      assign rad_in[s] = rad_r[s-1];
    end

    always_comb begin
      st_nxt[s]  = st_in[s];
      rad_nxt[s] = rad_in[s];
      for (int j = 0; j < acs_pkg::SQ_PER_STAGE; j++) begin
        if (s * acs_pkg::SQ_PER_STAGE + j < acs_pkg::ROOT_W) begin
          st_nxt[s]  = acs_pkg::sqrt_step(st_nxt[s],
                                          rad_nxt[s][acs_pkg::RADICAND_W-1 -: 2]);
          rad_nxt[s] = rad_nxt[s] << 2;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in[s];
      end
      in_r[s]  <= in_in[s];
      st_r[s]  <= st_nxt[s];
      rad_r[s] <= rad_nxt[s];
    end
  end

  assign distance = '{valid:     vld_r[acs_pkg::SQ_STAGES-1],
                      in_sprite: in_r[acs_pkg::SQ_STAGES-1],
                      dist_q8:   st_r[acs_pkg::SQ_STAGES-1].root};

endmodule
`default_nettype wire

@@ hw/rtl/acs_shade.sv @@
// coverage from distance, then premultiplied channel scaling (two stages)
`default_nettype none
module acs_shade (
  input  logic           clk,
  input  logic           rst_n,
  input  acs_pkg::dist_t distance,
  input  acs_pkg::cfg_t  cfg,
  output acs_pkg::argb_t px
);

  logic                            va_r;
  logic [acs_pkg::COV_W-1:0]       cov_a_r;
  logic [3*acs_pkg::CHAN_W-1:0]    rgb_a_r;
  acs_pkg::argb_t                  px_r;

  logic [acs_pkg::COV_W-1:0]       inner_cov, outer_cov, cov_nxt;
  logic [3*acs_pkg::CHAN_W-1:0]    rgb_nxt;
  acs_pkg::argb_t                  px_nxt;

  always_comb begin
    inner_cov = acs_pkg::disc_cov(cfg.radius, distance.dist_q8);
    outer_cov = acs_pkg::disc_cov(cfg.radius + acs_pkg::RAD_W'(acs_pkg::RING_WIDTH),
                                  distance.dist_q8);
    if (!distance.in_sprite) begin
      cov_nxt = '0;
    end else if (cfg.ring_mode) begin
      cov_nxt = outer_cov - inner_cov;
    end else begin
      cov_nxt = inner_cov;
    end
    rgb_nxt = cfg.ring_mode ? acs_pkg::palette(acs_pkg::COLOR_WHITE)
                            : acs_pkg::palette(cfg.color_index);
  end

  always_comb begin
    px_nxt.valid = va_r;
    px_nxt.alpha = acs_pkg::scale_chan(cov_a_r, 8'hFF);
    px_nxt.red   = acs_pkg::scale_chan(cov_a_r, rgb_a_r[23:16]);
    px_nxt.green = acs_pkg::scale_chan(cov_a_r, rgb_a_r[15:8]);
    px_nxt.blue  = acs_pkg::scale_chan(cov_a_r, rgb_a_r[7:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r       <= 1'b0;
      px_r.valid <= 1'b0;
    end else begin
      va_r       <= distance.valid;
      px_r.valid <= px_nxt.valid;
    end
    cov_a_r    <= cov_nxt;
    rgb_a_r    <= rgb_nxt;
    px_r.alpha <= px_nxt.alpha;
    px_r.red   <= px_nxt.red;
    px_r.green <= px_nxt.green;
    px_r.blue  <= px_nxt.blue;
  end

  assign px = px_r;

endmodule
`default_nettype wire
